// ===== sv/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// Each macro samples on the rising edge of clk and holds off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define IMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition on one edge is followed by another on the next edge.
`define IMF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/imf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imf_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int MIN_DIM    = 3;
    localparam int WIN_N      = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // Window: rows top [0..2], middle [3..5], bottom [6..8]; newest column on the right
    typedef pix_t [WIN_N-1:0] imf_win_t;

    // Per-beat tag that travels beside the pixel data
    typedef struct packed {
        logic                 emit;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } imf_meta_t;

    typedef struct packed {
        pix_t lo;
        pix_t md;
        pix_t hi;
    } imf_sort3_t;

    function automatic imf_sort3_t imf_sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t       x;
        pix_t       y;
        pix_t       z;
        pix_t       t;
        imf_sort3_t r;
        x = a;
        y = b;
        z = c;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        r.lo = x;
        r.md = y;
        r.hi = z;
        return r;
    endfunction

    function automatic pix_t imf_med3(input pix_t a, input pix_t b, input pix_t c);
        imf_sort3_t s;
        s = imf_sort3(a, b, c);
        return s.md;
    endfunction

    function automatic pix_t imf_max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t imf_min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/imf_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-stage median-of-nine: sort columns, then reduce lows/mids/highs.
module imf_median
    import imf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  wire imf_win_t  win_in,
    input  wire imf_meta_t meta_in,
    output imf_meta_t      meta_out,
    output pix_t           med_out
);

    imf_sort3_t col_sort [3];
    imf_sort3_t a_col_reg [3];
    imf_meta_t  a_meta_reg;
    pix_t       b_lo_reg;
    pix_t       b_md_reg;
    pix_t       b_hi_reg;
    imf_meta_t  b_meta_reg;

    // Sort each window column top to bottom
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            col_sort[k] = imf_sort3(win_in[k], win_in[3 + k], win_in[6 + k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_meta_reg <= '0;
            b_meta_reg <= '0;
        end
        else if (adv)
        begin
            a_meta_reg <= meta_in;
            b_meta_reg <= a_meta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_col_reg[k] <= col_sort[k];
            end
            // Median lies between the largest low, middle mid and smallest high
            b_lo_reg <= imf_max3(a_col_reg[0].lo, a_col_reg[1].lo, a_col_reg[2].lo);
            b_md_reg <= imf_med3(a_col_reg[0].md, a_col_reg[1].md, a_col_reg[2].md);
            b_hi_reg <= imf_min3(a_col_reg[0].hi, a_col_reg[1].hi, a_col_reg[2].hi);
        end
    end

    assign meta_out = b_meta_reg;
    assign med_out  = imf_med3(b_lo_reg, b_md_reg, b_hi_reg);

endmodule

`default_nettype wire

// ===== sv/image_median3x3_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// pixel    | in        | in_valid/in_ready  | pixel_in
// result   | out       | out_valid/out_ready| median_out, center_col, center_row, frame_last
// config   | in        | cfg_write          | cfg_addr, cfg_data
//
// One pixel beat per clock while results drain; a window's last beat passes stage 1,
// the window register and both median stage registers ahead of the output register.
// The line memory port (read on accept, write as it leaves stage 1) sets that rate.
// Reset clears counters and pipeline valids; line memory contents are left as is,
// no clearing pass, since border pixels never reach a result.
// When the output register is full and not taken, the pipeline advances only
// while its last stage holds no result; otherwise it holds and in_ready drops.
module image_median3x3_filter
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIX_W-1:0]      pixel_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PIX_W-1:0]           median_out,
    output logic [COL_OUT_W-1:0]       center_col,
    output logic [ROW_W-1:0]           center_row,
    output logic                       frame_last,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CW1   = CW + 1;
    localparam int RW1   = ROW_W + 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CX    = CW + COL_OUT_W;
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [ROW_W-1:0] RST_H = 16'd480;

    // Effective frame size, clamped on write
    logic [WW-1:0]    ew_reg;
    logic [ROW_W-1:0] eh_reg;
    logic [WW-1:0]    ew_cfg;
    logic [ROW_W-1:0] eh_cfg;

    // Raster position of the next pixel
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [CW1-1:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             col_wrap;
    logic             row_wrap;

    // Line memory: [15:8] two rows up, [7:0] one row up
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    // Stage 1: pixel waiting for its memory read data
    logic             s1_valid_reg;
    pix_t             s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    imf_meta_t        s1_meta_reg;
    imf_meta_t        in_meta;
    logic [CW-1:0]    col_m1;
    logic [CX-1:0]    col_m1_ext;

    // Stage 2: window register and its tag
    imf_win_t         win_reg;
    imf_meta_t        s2_meta_reg;

    imf_meta_t        b_meta;
    pix_t             b_med;

    logic             adv;
    logic             in_fire;
    logic             out_valid_reg;
    pix_t             median_reg;
    logic [COL_OUT_W-1:0] ccol_reg;
    logic [ROW_W-1:0] crow_reg;
    logic             last_reg;

    // Advance unless a finished result would run into an untaken one
    assign adv      = !out_valid_reg || out_ready || !b_meta.emit;
    assign in_ready = adv;
    assign in_fire  = in_valid && adv;

    // Clamp configuration values
    always_comb
    begin
        if (32'(cfg_data[WIDTH_W-1:0]) > MAX_WIDTH)
        begin
            ew_cfg = WW'(MAX_WIDTH);
        end
        else if (cfg_data[WIDTH_W-1:0] < WIDTH_W'(MIN_DIM))
        begin
            ew_cfg = WW'(MIN_DIM);
        end
        else
        begin
            ew_cfg = WW'(cfg_data[WIDTH_W-1:0]);
        end
        eh_cfg = (cfg_data < CFG_DATA_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg_data;
    end

    // Raster position and the tag of the incoming beat
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + CW1'(1);
        row_inc    = {1'b0, row_reg} + RW1'(1);
        col_wrap   = col_inc >= CW1'(ew_reg);
        row_wrap   = row_inc >= {1'b0, eh_reg};
        col_m1     = col_reg - CW'(1);
        col_m1_ext = CX'(col_m1);
        in_meta.emit = (col_reg >= CW'(2)) && (row_reg >= ROW_W'(2));
        in_meta.col  = col_m1_ext[COL_OUT_W-1:0];
        in_meta.row  = row_reg - ROW_W'(1);
        in_meta.last = col_wrap && row_wrap;
    end

    // Configuration and counters; any register write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg  <= WW'(RST_W);
            eh_reg  <= RST_H;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  ew_reg <= ew_cfg;
                REG_IMAGE_HEIGHT: eh_reg <= eh_cfg;
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Read the column on accept, write it back as the beat leaves stage 1.
    // A column is read again only a full row later, after its write has landed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_reg <= mem[col_reg];
        end
        if (s1_valid_reg && adv)
        begin
            mem[s1_col_reg] <= {rd_reg[PIX_W-1:0], s1_pix_reg};
        end
    end

    // Pipeline valids and tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_meta_reg  <= '0;
            s2_meta_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s1_meta_reg  <= in_valid ? in_meta : '0;
            s2_meta_reg  <= s1_meta_reg;
        end
    end

    // Stage 1 payload and window shift
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg <= pixel_in;
            s1_col_reg <= col_reg;
        end
        if (s1_valid_reg && adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= rd_reg[2*PIX_W-1:PIX_W];
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= rd_reg[PIX_W-1:0];
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_pix_reg;
        end
    end

    imf_median u_median (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .win_in   (win_reg),
        .meta_in  (s2_meta_reg),
        .meta_out (b_meta),
        .med_out  (b_med)
    );

    // Output register: drop on take, load when a result arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && b_meta.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_meta.emit)
        begin
            median_reg <= b_med;
            ccol_reg   <= b_meta.col;
            crow_reg   <= b_meta.row;
            last_reg   <= b_meta.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign median_out = median_reg;
    assign center_col = ccol_reg;
    assign center_row = crow_reg;
    assign frame_last = last_reg;

`include "assert_macros.svh"

    `IMF_ASSERT(a_no_overwrite,
        !(out_valid_reg && !out_ready && adv && b_meta.emit),
        "result would overwrite an untaken result")
    `IMF_ASSERT(a_col_in_frame, CW1'(col_reg) < CW1'(ew_reg),
        "column counter outside frame width")
    `IMF_ASSERT(a_row_in_frame, row_reg < eh_reg,
        "row counter outside frame height")
    `IMF_ASSERT_NEXT(a_accept_to_s1, in_fire, s1_valid_reg,
        "accepted beat did not reach stage 1")

endmodule

`default_nettype wire
